// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the receiver modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property holds at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// expression never true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ===== sv/cobsrx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobsrx_pkg
// Shared types, constants and the CRC-8 step for the COBS frame receiver.
// ----------------------------------------------------------------------------
package cobsrx_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [8:0] FRAME_OVERHEAD = 9'd5;
    localparam logic [8:0] POS_MAX        = 9'h1FF;

    localparam logic [8:0] IDX_DIST  = 9'd1;
    localparam logic [8:0] IDX_CHECK = 9'd2;
    localparam logic [8:0] IDX_LEN   = 9'd3;
    localparam logic [8:0] IDX_ID    = 9'd4;

    localparam logic CFG_START_MARKER = 1'b0;
    localparam logic CFG_MAX_PAYLOAD  = 1'b1;

    typedef enum logic [1:0] {
        KIND_ID      = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_END     = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] position;
        logic       has_end;
        logic       good;
    } t_op;

    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== sv/cobsrx_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobsrx_front
// Accepts raw link bytes, tracks framing, undoes stuffing, runs the CRC and
// hands one operation per result-bearing byte to the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cobsrx_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_wdata,
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_full,
    output logic              o_push,
    output cobsrx_pkg::t_op   o_op
);
    import cobsrx_pkg::*;

    logic [7:0] r_start_marker;
    logic [7:0] r_max_payload;

    logic       r_in_frame,   n_in_frame;
    logic       r_finished,   n_finished;
    logic [8:0] r_byte_count, n_byte_count;
    logic [8:0] r_next_pos,   n_next_pos;
    logic       r_broken,     n_broken;
    logic [7:0] r_check,      n_check;
    logic [7:0] r_payload_len, n_payload_len;
    logic [7:0] r_crc,        n_crc;

    logic       w_accept;
    logic       w_stuffed;
    logic [7:0] w_dec;
    logic [7:0] w_crc;
    logic [9:0] w_sum;
    logic       w_end;
    logic [8:0] w_pos;

    assign o_rx_ready = !i_full;
    assign w_accept   = i_rx_valid && !i_full;

    assign w_stuffed = !r_broken && (r_byte_count == r_next_pos);
    assign w_dec     = w_stuffed ? r_start_marker : i_rx_byte;
    assign w_crc     = crc8_feed(r_crc, w_dec);
    assign w_sum     = {1'b0, r_next_pos} + {2'b00, i_rx_byte};
    assign w_end     = r_byte_count == ({1'b0, r_payload_len} + (FRAME_OVERHEAD - 9'd1));
    assign w_pos     = r_byte_count - FRAME_OVERHEAD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= 8'd0;
            r_max_payload  <= 8'd255;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_MARKER: r_start_marker <= i_cfg_wdata;
                CFG_MAX_PAYLOAD:  r_max_payload  <= i_cfg_wdata;
                default:          r_max_payload  <= r_max_payload;
            endcase
        end
    end

    always_comb begin
        n_in_frame    = r_in_frame;
        n_finished    = r_finished;
        n_byte_count  = r_byte_count;
        n_next_pos    = r_next_pos;
        n_broken      = r_broken;
        n_check       = r_check;
        n_payload_len = r_payload_len;
        n_crc         = r_crc;
        o_push        = 1'b0;
        o_op          = '0;
        if (w_accept) begin
            priority if (i_rx_byte == r_start_marker) begin
                n_in_frame    = 1'b1;
                n_finished    = 1'b0;
                n_byte_count  = IDX_DIST;
                n_next_pos    = 9'd0;
                n_broken      = 1'b0;
                n_check       = 8'd0;
                n_payload_len = 8'd0;
                n_crc         = CRC_INIT;
            end else if (!r_in_frame || r_finished) begin
                n_in_frame = r_in_frame;
            end else if (r_byte_count == IDX_DIST) begin
                if (i_rx_byte == 8'd0) begin
                    n_broken = 1'b1;
                end else begin
                    n_next_pos = {1'b0, i_rx_byte} + 9'd1;
                end
                n_byte_count = IDX_CHECK;
            end else begin
                if (w_stuffed) begin
                    if (i_rx_byte == 8'd0) begin
                        n_broken = 1'b1;
                    end else begin
                        n_next_pos = (w_sum > {1'b0, POS_MAX}) ? POS_MAX : w_sum[8:0];
                    end
                end
                priority if (r_byte_count == IDX_CHECK) begin
                    n_check      = w_dec;
                    n_byte_count = IDX_LEN;
                end else if (r_byte_count == IDX_LEN) begin
                    if (w_dec > r_max_payload) begin
                        n_in_frame   = 1'b0;
                        n_byte_count = 9'd0;
                    end else begin
                        n_payload_len = w_dec;
                        n_byte_count  = IDX_ID;
                    end
                end else begin
                    n_crc         = w_crc;
                    o_push        = 1'b1;
                    o_op.kind     = (r_byte_count == IDX_ID) ? KIND_ID : KIND_PAYLOAD;
                    o_op.data     = w_dec;
                    o_op.position = (r_byte_count == IDX_ID) ? 8'd0 : w_pos[7:0];
                    o_op.has_end  = w_end;
                    o_op.good     = w_end && (w_crc == r_check) && !n_broken;
                    n_finished    = w_end;
                    n_byte_count  = r_byte_count + 9'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame    <= 1'b0;
            r_finished    <= 1'b0;
            r_byte_count  <= 9'd0;
            r_next_pos    <= 9'd0;
            r_broken      <= 1'b0;
            r_check       <= 8'd0;
            r_payload_len <= 8'd0;
            r_crc         <= CRC_INIT;
        end else begin
            r_in_frame    <= n_in_frame;
            r_finished    <= n_finished;
            r_byte_count  <= n_byte_count;
            r_next_pos    <= n_next_pos;
            r_broken      <= n_broken;
            r_check       <= n_check;
            r_payload_len <= n_payload_len;
            r_crc         <= n_crc;
        end
    end

    `ASSERT_CLK(a_finished_in_frame, i_clk, i_rst_n, r_finished |-> r_in_frame)

endmodule

// ===== sv/cobsrx_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobsrx_fifo
// Short operation queue between the byte front end and the result back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cobsrx_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cobsrx_pkg::t_op   i_wr_op,
    input  logic              i_pop,
    output cobsrx_pkg::t_op   o_rd_op,
    output logic              o_empty,
    output logic              o_full
);
    import cobsrx_pkg::*;

    t_op                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    assign o_rd_op = r_mem[r_rd_ptr];
    assign o_empty = r_count == '0;
    assign o_full  = r_count == (FIFO_AW+1)'(FIFO_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full)
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty)

endmodule

// ===== sv/cobsrx_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobsrx_back
// Expands queued operations into result beats through an output register;
// an operation that closes a frame yields a data beat and an end beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cobsrx_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cobsrx_pkg::t_op   i_op,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_data,
    output logic [7:0]        o_position,
    output logic              o_good,
    output logic              o_last
);
    import cobsrx_pkg::*;

    logic       r_valid;
    logic       r_phase;
    t_kind      r_kind;
    logic [7:0] r_data;
    logic [7:0] r_position;
    logic       r_good;
    logic       r_last;

    logic       w_load;

    assign w_load = (!r_valid || i_res_ready) && !i_empty;
    assign o_pop  = w_load && (r_phase || !i_op.has_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_phase <= !r_phase && i_op.has_end;
            end else if (i_res_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_phase) begin
                r_kind     <= KIND_END;
                r_data     <= 8'd0;
                r_position <= 8'd0;
                r_good     <= i_op.good;
                r_last     <= 1'b1;
            end else begin
                r_kind     <= i_op.kind;
                r_data     <= i_op.data;
                r_position <= i_op.position;
                r_good     <= 1'b0;
                r_last     <= !i_op.has_end;
            end
        end
    end

    assign o_res_valid = r_valid;
    assign o_kind      = r_kind;
    assign o_data      = r_data;
    assign o_position  = r_position;
    assign o_good      = r_good;
    assign o_last      = r_last;

    `ASSERT_CLK(a_phase_has_head, i_clk, i_rst_n, r_phase |-> !i_empty)
    `ASSERT_CLK(a_end_is_last, i_clk, i_rst_n, (r_valid && r_kind == KIND_END) |-> r_last)

endmodule

// ===== sv/cobs_crc8_frame_receiver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobs_crc8_frame_receiver_top
// COBS-stuffed frame receiver with CRC-8 check over id and payload.
// ----------------------------------------------------------------------------
// Input channel: one raw link byte per beat on i_rx_byte (i_rx_valid/o_rx_ready).
// Output channel: one decoded result per beat (o_res_valid/i_res_ready):
//   frame id, each payload byte with its position, and an end beat with
//   o_good. o_last marks the final beat caused by one input byte.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_index
//   (0 start marker, 1 max payload) in the same cycle; write only when idle.
// Path: an accepted byte's operation goes through the queue into the output
//   register; an end beat is loaded once its data beat has been taken.
// Throughput: one byte per cycle while the queue has room; the closing payload
//   byte of a frame gives two beats, an extra beat at the output per frame.
// The four-entry operation queue decouples byte intake from result delivery;
//   when the receiver stalls, the queue fills and o_rx_ready drops.
// Reset: synchronous, active low; the block hunts for a marker, registers
//   return to marker 0 and max payload 255, and the queue empties.
// ----------------------------------------------------------------------------
module cobs_crc8_frame_receiver_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_data,
    output logic [7:0] o_position,
    output logic       o_good,
    output logic       o_last
);
    import cobsrx_pkg::*;

    logic w_push;
    logic w_pop;
    logic w_empty;
    logic w_full;
    t_op  w_wr_op;
    t_op  w_rd_op;

    cobsrx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_op        (w_wr_op)
    );

    cobsrx_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wr_op (w_wr_op),
        .i_pop   (w_pop),
        .o_rd_op (w_rd_op),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    cobsrx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_rd_op),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_kind      (o_kind),
        .o_data      (o_data),
        .o_position  (o_position),
        .o_good      (o_good),
        .o_last      (o_last)
    );

endmodule

// ===== test/tb_cobs_rx_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cobs_rx_checker
// Watches both channels of the COBS frame receiver, decodes every accepted
// link byte with its own destuffing and CRC-8 logic, and compares each result
// beat in order against the decoded expectation.
// ----------------------------------------------------------------------------
module tb_cobs_rx_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_rx_valid,
    input  logic       i_rx_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_data,
    input  logic [7:0] i_position,
    input  logic       i_good,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_pending
);
    import cobsrx_pkg::*;

    typedef struct {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] position;
        logic       good;
        logic       last;
    } t_beat;

    t_beat      expected_beats[$];

    logic [7:0] marker;
    logic [7:0] max_len;
    logic       in_frame;
    logic       done;
    logic       broken;
    logic [8:0] count;
    logic [8:0] next_stuffed;
    logic [7:0] check_byte;
    logic [7:0] len_byte;
    logic [7:0] crc;
    int         fails = 0;
    int         beat_no = 0;

    function automatic logic [7:0] crc8_next(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc_in;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ b[i];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    task automatic add_beat(input t_kind k, input logic [7:0] d, input logic [7:0] p,
                            input logic g, input logic l);
        t_beat e;
        e.kind     = k;
        e.data     = d;
        e.position = p;
        e.good     = g;
        e.last     = l;
        expected_beats.push_back(e);
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic [7:0] d;
        logic [8:0] idx;
        logic [8:0] pos9;
        logic [9:0] np;
        logic       ends;
        if (b == marker) begin
            in_frame     = 1'b1;
            done         = 1'b0;
            count        = IDX_DIST;
            next_stuffed = '0;
            broken       = 1'b0;
            check_byte   = '0;
            len_byte     = '0;
            crc          = CRC_INIT;
            return;
        end
        if (!in_frame || done)
            return;
        idx = count;
        if (idx == IDX_DIST) begin
            if (b == 8'h00)
                broken = 1'b1;
            else
                next_stuffed = {1'b0, b} + 9'd1;
            count = IDX_CHECK;
            return;
        end
        d = b;
        if (!broken && idx == next_stuffed) begin
            d = marker;
            if (b == 8'h00) begin
                broken = 1'b1;
            end else begin
                np = {1'b0, next_stuffed} + {2'b00, b};
                next_stuffed = (np > {1'b0, POS_MAX}) ? POS_MAX : np[8:0];
            end
        end
        if (idx == IDX_CHECK) begin
            check_byte = d;
            count      = IDX_LEN;
            return;
        end
        if (idx == IDX_LEN) begin
            if (d > max_len) begin
                in_frame = 1'b0;
                count    = '0;
                return;
            end
            len_byte = d;
            count    = IDX_ID;
            return;
        end
        crc  = crc8_next(crc, d);
        ends = (idx == {1'b0, len_byte} + FRAME_OVERHEAD - 9'd1);
        pos9 = idx - FRAME_OVERHEAD;
        if (idx == IDX_ID)
            add_beat(KIND_ID, d, 8'h00, 1'b0, !ends);
        else
            add_beat(KIND_PAYLOAD, d, pos9[7:0], 1'b0, !ends);
        if (ends) begin
            add_beat(KIND_END, 8'h00, 8'h00, (crc == check_byte) && !broken, 1'b1);
            done = 1'b1;
        end
        count = idx + 9'd1;
    endtask

    task automatic compare_beat();
        t_beat e;
        if (expected_beats.size() == 0) begin
            fails++;
            if (fails <= 10)
                $display("beat %0d unexpected: kind %0d data %02h pos %0d good %0b last %0b",
                         beat_no, i_kind, i_data, i_position, i_good, i_last);
        end else begin
            e = expected_beats.pop_front();
            if (i_kind !== e.kind || i_data !== e.data || i_position !== e.position ||
                i_good !== e.good || i_last !== e.last) begin
                fails++;
                if (fails <= 10) begin
                    $write("beat %0d mismatch: exp kind %0d data %02h pos %0d ",
                           beat_no, e.kind, e.data, e.position);
                    $display("good %0b last %0b, got kind %0d data %02h pos %0d good %0b last %0b",
                             e.good, e.last, i_kind, i_data, i_position, i_good, i_last);
                end
            end
        end
        beat_no++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            marker       = 8'h00;
            max_len      = 8'hFF;
            in_frame     = 1'b0;
            done         = 1'b0;
            broken       = 1'b0;
            count        = '0;
            next_stuffed = '0;
            check_byte   = '0;
            len_byte     = '0;
            crc          = CRC_INIT;
            expected_beats.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_START_MARKER)
                    marker = i_cfg_wdata;
                else
                    max_len = i_cfg_wdata;
            end
            if (i_rx_valid && i_rx_ready)
                decode_byte(i_rx_byte);
            if (i_res_valid && i_res_ready)
                compare_beat();
        end
        o_fail_count <= fails;
        o_pending    <= expected_beats.size();
    end

endmodule

// ===== test/tb_cobs_crc8_frame_receiver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cobs_crc8_frame_receiver_top
// Drives link bytes into the COBS frame receiver: a short directed run of
// stuffing corner cases, then phases of random marker and length limits with
// well-formed stuffed frames, truncated and oversized frames and raw noise.
// Both channels idle at random; the checker beside the block does the compare.
// ----------------------------------------------------------------------------
module tb_cobs_crc8_frame_receiver_top;
    import cobsrx_pkg::*;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_index = 1'b0;
    logic [7:0] i_cfg_wdata = 8'h00;
    logic       i_rx_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_res_ready = 1'b0;
    logic       o_rx_ready;
    logic       o_res_valid;
    logic [1:0] o_kind;
    logic [7:0] o_data;
    logic [7:0] o_position;
    logic       o_good;
    logic       o_last;

    int         fail_count;
    int         pending;
    bit         src_quiet  = 1'b0;
    bit         sink_quiet = 1'b0;
    int         sink_hold  = 0;
    int         sink_roll;
    int         sent_count = 0;
    logic [7:0] cur_marker = 8'h00;
    logic [7:0] body[0:259];
    logic [7:0] line_bytes[0:259];
    logic [7:0] frame_bytes[$];

    always #4 i_clk = ~i_clk;

    cobs_crc8_frame_receiver_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_kind      (o_kind),
        .o_data      (o_data),
        .o_position  (o_position),
        .o_good      (o_good),
        .o_last      (o_last)
    );

    tb_cobs_rx_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_rx_valid   (i_rx_valid),
        .i_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .i_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .i_kind       (o_kind),
        .i_data       (o_data),
        .i_position   (o_position),
        .i_good       (o_good),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    // hold ready high or low for random stretches
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
        end else if (sink_quiet) begin
            i_res_ready <= 1'b1;
            sink_hold = 4;
        end else begin
            sink_roll = $urandom_range(0, 99);
            if (sink_roll < 60) begin
                i_res_ready <= 1'b1;
                sink_hold = $urandom_range(0, 7);
            end else if (sink_roll < 92) begin
                i_res_ready <= 1'b0;
                sink_hold = $urandom_range(0, 2);
            end else begin
                i_res_ready <= 1'b0;
                sink_hold = $urandom_range(8, 40);
            end
        end
    end

    function automatic int idle_len();
        int r;
        if (src_quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit counted);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!(i_rx_valid && o_rx_ready));
        if (counted)
            sent_count++;
    endtask

    task automatic send_frame();
        while (frame_bytes.size() != 0)
            send_byte(frame_bytes.pop_front(), 1'b1);
    endtask

    // drop valid and wait out every pending beat plus the pipeline
    task automatic drain();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // stuff a frame of plen payload bytes for the current marker
    task automatic build_frame(input int plen, input bit good_crc, input bit extreme);
        int         tries;
        int         p;
        int         cur;
        int         d;
        int         lo;
        bit         ok;
        logic [7:0] c;
        tries = 0;
        do begin
            tries++;
            for (int i = 4; i <= plen + 4; i++) begin
                if (extreme)
                    body[i] = (i == 4) ? 8'hFF : ((i % 2) ? 8'h00 : 8'hFF);
                else
                    body[i] = ($urandom_range(0, 99) < 15) ? cur_marker : 8'($urandom);
            end
            if (!extreme) begin
                p = $urandom_range(60, 200);
                while (p <= plen + 4) begin
                    body[p] = cur_marker;
                    p += $urandom_range(60, 200);
                end
            end
            c = CRC_INIT;
            for (int i = 4; i <= plen + 4; i++) begin
                c = c ^ body[i];
                repeat (8) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            end
            body[2] = good_crc ? c : c ^ 8'($urandom_range(1, 255));
            body[3] = 8'(plen);
            line_bytes[0] = cur_marker;
            cur = 1;
            ok  = 1'b1;
            for (p = 2; p <= plen + 4; p++) begin
                if (body[p] == cur_marker) begin
                    d = p - cur;
                    if (d > 255 || d == cur_marker)
                        ok = 1'b0;
                    line_bytes[cur] = 8'(d);
                    cur = p;
                end else begin
                    line_bytes[p] = body[p];
                end
            end
            lo = plen + 5 - cur;
            if (lo > 255) begin
                ok = 1'b0;
            end else begin
                d = $urandom_range(lo, 255);
                if (d == cur_marker)
                    ok = 1'b0;
                line_bytes[cur] = 8'(d);
            end
        end while (!ok && tries < 300);
        frame_bytes.delete();
        for (int i = 0; i <= plen + 4; i++)
            frame_bytes.push_back(line_bytes[i]);
    endtask

    initial begin
        int         ph;
        int         start;
        int         r;
        int         plen;
        int         n;
        int         mx;
        logic [7:0] m;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default marker zero: hunting, stuffed zeros, bytes after a finished frame
        send_byte(8'hA5, 1'b0);
        build_frame(2, 1'b1, 1'b1);
        send_frame();
        send_byte(8'h37, 1'b0);
        drain();

        // nonzero marker: zero distances and a restart mid-frame
        write_reg(CFG_START_MARKER, 8'h7E);
        cur_marker = 8'h7E;
        frame_bytes = '{8'h7E, 8'h00, 8'h11, 8'h01, 8'h22, 8'h33};
        send_frame();
        frame_bytes = '{8'h7E, 8'h03, 8'h55, 8'h00, 8'h00};
        send_frame();
        frame_bytes = '{8'h7E, 8'h05, 8'h22};
        send_frame();
        build_frame(0, 1'b1, 1'b1);
        send_frame();

        sent_count = 0;
        ph = 0;
        while (sent_count < 1650) begin
            case (ph)
                0: begin m = 8'hFF; mx = 0; end
                1: begin m = 8'h00; mx = 255; end
                2: begin m = 8'($urandom); mx = $urandom_range(1, 30); end
                3: begin m = 8'h01; mx = 255; end
                default: begin
                    m  = 8'($urandom);
                    mx = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 40);
                end
            endcase
            drain();
            write_reg(CFG_START_MARKER, m);
            write_reg(CFG_MAX_PAYLOAD, 8'(mx));
            cur_marker = m;
            src_quiet  = ($urandom_range(0, 3) == 0);
            sink_quiet = ($urandom_range(0, 3) == 0);
            if (ph == 1) begin
                build_frame(255, 1'b1, 1'b0);
                send_frame();
            end
            start = sent_count;
            while (sent_count - start < 220 && sent_count < 1650) begin
                if ($urandom_range(0, 99) < 4)
                    drain();
                r    = $urandom_range(0, 99);
                plen = ($urandom_range(0, 99) < 3) ? mx : $urandom_range(0, (mx < 12) ? mx : 12);
                if (r < 65) begin
                    build_frame(plen, $urandom_range(0, 4) != 0, 1'b0);
                    send_frame();
                end else if (r < 75) begin
                    build_frame(plen, 1'b1, 1'b0);
                    n = $urandom_range(1, frame_bytes.size() - 1);
                    while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
                    send_frame();
                end else if (r < 85 && mx < 255) begin
                    build_frame($urandom_range(mx + 1, (mx + 16 > 255) ? 255 : mx + 16),
                                1'b1, 1'b0);
                    n = $urandom_range(4, 6);
                    while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
                    send_frame();
                end else begin
                    n = $urandom_range(1, 12);
                    repeat (n)
                        send_byte(($urandom_range(0, 9) == 0) ? cur_marker : 8'($urandom), 1'b1);
                end
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
            end
            ph++;
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
